FILE: hdl/rrht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrht_pkg
// Shared types and constants of the rounded rectangle hit test: register
// map, corner order and the enable group of the pipelined squarer.
// ----------------------------------------------------------------------------
package rrht_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int BOX_W       = 16;
  localparam int RADII_W     = 32;
  localparam int NUM_BOX     = 4;
  localparam int NUM_CORNERS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_LEFT          = 3'd0,
    REG_BOX_TOP           = 3'd1,
    REG_BOX_RIGHT         = 3'd2,
    REG_BOX_BOTTOM        = 3'd3,
    REG_UPPER_LEFT_RADII  = 3'd4,
    REG_UPPER_RIGHT_RADII = 3'd5,
    REG_LOWER_RIGHT_RADII = 3'd6,
    REG_LOWER_LEFT_RADII  = 3'd7
  } cfg_reg_e;

  localparam int BOX_LEFT   = 0;
  localparam int BOX_TOP    = 1;
  localparam int BOX_RIGHT  = 2;
  localparam int BOX_BOTTOM = 3;

  localparam int CORNER_UL = 0;
  localparam int CORNER_UR = 1;
  localparam int CORNER_LR = 2;
  localparam int CORNER_LL = 3;

  typedef struct packed {
    logic part_en;
    logic sum_en;
  } sqr_en_t;

endpackage

FILE: hdl/rrht_sqr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrht_sqr
// Two-stage squarer: splits the operand into halves, registers the three
// half-width partial products, then registers their weighted sum.
// ----------------------------------------------------------------------------
module rrht_sqr #(
  parameter int HALF_W = 16
) (
  input  logic                  clk_i,
  input  rrht_pkg::sqr_en_t     en_i,
  input  logic [2*HALF_W-1:0]   val_i,
  output logic [4*HALF_W-1:0]   sq_o
);
  import rrht_pkg::*;

  localparam int W2 = 2 * HALF_W;
  localparam int W4 = 4 * HALF_W;

  logic [HALF_W-1:0] hi, lo;
  logic [W2-1:0]     hh_d, hl_d, ll_d;
  logic [W2-1:0]     hh_q, hl_q, ll_q;
  logic [W4-1:0]     sq_d, sq_q;

  assign hi   = val_i[W2-1:HALF_W];
  assign lo   = val_i[HALF_W-1:0];
  assign hh_d = W2'(hi) * W2'(hi);
  assign hl_d = W2'(hi) * W2'(lo);
  assign ll_d = W2'(lo) * W2'(lo);

  always_ff @(posedge clk_i) begin
    if (en_i.part_en) begin
      hh_q <= hh_d;
      hl_q <= hl_d;
      ll_q <= ll_d;
    end
  end

  assign sq_d = {hh_q, W2'(0)} + (W4'(hl_q) << (HALF_W + 1)) + W4'(ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

FILE: hdl/rounded_rect_point_hit_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_point_hit_test_top
// Hit test of a point against a box with four elliptical corners.
// ----------------------------------------------------------------------------
// Usage:
//   Program the box edges and corner radii through the write port while the
//   block is idle; a write lands at the clock edge where cfg_we_i is high.
//   Points enter on the input channel (valid/stall); one inside flag per
//   point leaves on the output channel in the same order.
// Stages and throughput:
//   Six register stages: edge offsets, corner pick, radius products,
//   squarer partials, squarer sum, final compare. A point accepted at one
//   edge passes these registers in that order before it shows on the
//   output; a stall holds it in place. One point per cycle is accepted
//   sustained while the output is not stalled; the radius products followed
//   by the squarers of the three products set the stage count.
// Stall:
//   Each stage holds while the one after it is full and held, so bubbles
//   close up and input is still taken while a result waits at the output.
// Reset:
//   Config registers and valid bits read zero, so the pipeline is empty.
// ----------------------------------------------------------------------------
module rounded_rect_point_hit_test_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]   point_x_i,
  input  logic signed [COORD_WIDTH-1:0]   point_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            inside_res_o,
  input  logic                            cfg_we_i,
  input  logic [rrht_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rrht_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rrht_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int W2 = 2 * COORD_WIDTH;
  localparam int W4 = 4 * COORD_WIDTH;
  localparam int NS = 6;

  logic [BOX_W-1:0]   box_q   [NUM_BOX];
  logic [RADII_W-1:0] radii_q [NUM_CORNERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BOX; i++) begin
        box_q[i] <= '0;
      end
      for (int i = 0; i < NUM_CORNERS; i++) begin
        radii_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BOX_LEFT:          box_q[BOX_LEFT]     <= cfg_data_i[BOX_W-1:0];
        REG_BOX_TOP:           box_q[BOX_TOP]      <= cfg_data_i[BOX_W-1:0];
        REG_BOX_RIGHT:         box_q[BOX_RIGHT]    <= cfg_data_i[BOX_W-1:0];
        REG_BOX_BOTTOM:        box_q[BOX_BOTTOM]   <= cfg_data_i[BOX_W-1:0];
        REG_UPPER_LEFT_RADII:  radii_q[CORNER_UL]  <= cfg_data_i[RADII_W-1:0];
        REG_UPPER_RIGHT_RADII: radii_q[CORNER_UR]  <= cfg_data_i[RADII_W-1:0];
        REG_LOWER_RIGHT_RADII: radii_q[CORNER_LR]  <= cfg_data_i[RADII_W-1:0];
        REG_LOWER_LEFT_RADII:  radii_q[CORNER_LL]  <= cfg_data_i[RADII_W-1:0];
        default: ;
      endcase
    end
  end

  logic [W-1:0] left_w, top_w, right_w, bottom_w;
  logic [W-1:0] rx_w [NUM_CORNERS];
  logic [W-1:0] ry_w [NUM_CORNERS];
  logic         degen;

  assign left_w   = W'(box_q[BOX_LEFT]);
  assign top_w    = W'(box_q[BOX_TOP]);
  assign right_w  = W'(box_q[BOX_RIGHT]);
  assign bottom_w = W'(box_q[BOX_BOTTOM]);
  assign degen    = (left_w == right_w) || (top_w == bottom_w);

  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      rx_w[c] = radii_q[c][W-1:0];
      ry_w[c] = W'(radii_q[c] >> W);
    end
  end

  // Stage advance chain.
  logic [NS-1:0] adv;
  logic [NS-1:0] v_q;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: offsets from each edge.
  logic [W:0] dxl_d, dxr_d, dyt_d, dyb_d;
  logic [W:0] dxl_q, dxr_q, dyt_q, dyb_q;

  assign dxl_d = {point_x_i[W-1], point_x_i} - {left_w[W-1], left_w};
  assign dxr_d = {right_w[W-1], right_w} - {point_x_i[W-1], point_x_i};
  assign dyt_d = {point_y_i[W-1], point_y_i} - {top_w[W-1], top_w};
  assign dyb_d = {bottom_w[W-1], bottom_w} - {point_y_i[W-1], point_y_i};

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dxl_q <= dxl_d;
      dxr_q <= dxr_d;
      dyt_q <= dyt_d;
      dyb_q <= dyb_d;
    end
  end

  // Stage 2: box test and first corner whose quadrant holds the point.
  logic [NUM_CORNERS-1:0] hit;
  logic [W-1:0]           dxs   [NUM_CORNERS];
  logic [W-1:0]           dys   [NUM_CORNERS];
  logic                   in_box, found;
  logic [W-1:0]           adx_d, ady_d, rx_d, ry_d;
  logic [W-1:0]           adx_q, ady_q, rx_q, ry_q;
  logic                   fixed_d, val_d;
  logic [NS-2:1]          fixed_q, val_q;

  assign in_box = !(dxl_q[W] || dxr_q[W] || dyt_q[W] || dyb_q[W]);

  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      dxs[c] = (c == CORNER_UL || c == CORNER_LL) ? dxl_q[W-1:0] : dxr_q[W-1:0];
      dys[c] = (c == CORNER_UL || c == CORNER_UR) ? dyt_q[W-1:0] : dyb_q[W-1:0];
      hit[c] = (rx_w[c] != '0) && (ry_w[c] != '0) &&
               (dxs[c] < rx_w[c]) && (dys[c] < ry_w[c]);
    end
    adx_d = '0;
    ady_d = '0;
    rx_d  = '0;
    ry_d  = '0;
    for (int c = NUM_CORNERS - 1; c >= 0; c--) begin
      if (hit[c]) begin
        adx_d = rx_w[c] - dxs[c];
        ady_d = ry_w[c] - dys[c];
        rx_d  = rx_w[c];
        ry_d  = ry_w[c];
      end
    end
  end

  assign found   = |hit;
  assign fixed_d = !in_box || degen || !found;
  assign val_d   = in_box;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      adx_q      <= adx_d;
      ady_q      <= ady_d;
      rx_q       <= rx_d;
      ry_q       <= ry_d;
      fixed_q[1] <= fixed_d;
      val_q[1]   <= val_d;
    end
  end

  // Stage 3: radius products; the test is (adx*ry)^2 + (ady*rx)^2 <= (rx*ry)^2.
  logic [W2-1:0] p_q, q_q, r_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      p_q        <= W2'(adx_q) * W2'(ry_q);
      q_q        <= W2'(ady_q) * W2'(rx_q);
      r_q        <= W2'(rx_q) * W2'(ry_q);
      fixed_q[2] <= fixed_q[1];
      val_q[2]   <= val_q[1];
    end
  end

  // Stages 4 and 5: squares.
  sqr_en_t       sqr_en;
  logic [W4-1:0] lhs1, lhs2, rhs;

  assign sqr_en = '{part_en: adv[3], sum_en: adv[4]};

  rrht_sqr #(.HALF_W(W)) u_sqr_p (.clk_i(clk_i), .en_i(sqr_en), .val_i(p_q), .sq_o(lhs1));
  rrht_sqr #(.HALF_W(W)) u_sqr_q (.clk_i(clk_i), .en_i(sqr_en), .val_i(q_q), .sq_o(lhs2));
  rrht_sqr #(.HALF_W(W)) u_sqr_r (.clk_i(clk_i), .en_i(sqr_en), .val_i(r_q), .sq_o(rhs));

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      fixed_q[3] <= fixed_q[2];
      val_q[3]   <= val_q[2];
    end
    if (adv[4]) begin
      fixed_q[4] <= fixed_q[3];
      val_q[4]   <= val_q[3];
    end
  end

  // Stage 6: ellipse compare and output word.
  logic [W4:0] lhs_sum;
  logic        inside_d, inside_q;

  assign lhs_sum  = {1'b0, lhs1} + {1'b0, lhs2};
  assign inside_d = fixed_q[4] ? val_q[4] : (lhs_sum <= {1'b0, rhs});

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      inside_q <= inside_d;
    end
  end

  assign out_valid_o  = v_q[NS-1];
  assign inside_res_o = inside_q;

endmodule

FILE: hdl/rrht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrht_checker
// Port-level checks of the hit test: reset, stall origin, output hold and
// latency through the six stages.
// ----------------------------------------------------------------------------
module rrht_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic inside_res_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output word valid during reset");

  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output not blocked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(inside_res_o)))
    else $error("stalled output word changed");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not reach output in six cycles");

endmodule

bind rounded_rect_point_hit_test_top rrht_checker u_rrht_checker (.*);

FILE: dv/rounded_rect_point_hit_test_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_point_hit_test_top_tb
// Self-checking bench for the rounded rectangle hit test. Directed shapes
// cover degenerate, inverted, square-cornered and full-range boxes, then
// random shapes are programmed between drained phases and points are
// streamed with random gaps and output stalls, including one long output
// hold-off. Each inside flag is compared in order against a bench-side
// predictor of the elliptical corner test.
// ----------------------------------------------------------------------------
module rounded_rect_point_hit_test_top_tb;
  import rrht_pkg::*;

  localparam int LIMIT       = 800000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_PAUSE = 12;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_PTS   = 115;

  typedef struct {
    logic signed [BOX_W-1:0] x;
    logic signed [BOX_W-1:0] y;
    bit                      hit;
  } hit_expect_t;

  class hit_scoreboard;
    logic signed [BOX_W-1:0] box_l, box_t, box_r, box_b;
    logic [RADII_W-1:0]      radii [NUM_CORNERS];
    hit_expect_t             hit_q [$];
    int checked, errors, hits, misses;

    function new();
      box_l = '0;
      box_t = '0;
      box_r = '0;
      box_b = '0;
      for (int c = 0; c < NUM_CORNERS; c++) radii[c] = '0;
      checked = 0;
      errors = 0;
      hits = 0;
      misses = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_BOX_LEFT:          box_l = d[BOX_W-1:0];
        REG_BOX_TOP:           box_t = d[BOX_W-1:0];
        REG_BOX_RIGHT:         box_r = d[BOX_W-1:0];
        REG_BOX_BOTTOM:        box_b = d[BOX_W-1:0];
        REG_UPPER_LEFT_RADII:  radii[CORNER_UL] = d;
        REG_UPPER_RIGHT_RADII: radii[CORNER_UR] = d;
        REG_LOWER_RIGHT_RADII: radii[CORNER_LR] = d;
        REG_LOWER_LEFT_RADII:  radii[CORNER_LL] = d;
        default: ;
      endcase
    endfunction

    function bit point_hits(logic signed [BOX_W-1:0] px, logic signed [BOX_W-1:0] py);
      longint x, y, l, t, r, b, rx, ry, cx, cy, adx, ady;
      logic [127:0] dx2, dy2, rx2, ry2;
      bit west, north;
      x = px;
      y = py;
      l = box_l;
      t = box_t;
      r = box_r;
      b = box_b;
      if (x < l || x > r || y < t || y > b) return 1'b0;
      if (l == r || t == b) return 1'b1;
      for (int c = 0; c < NUM_CORNERS; c++) begin
        rx = radii[c][15:0];
        ry = radii[c][31:16];
        if (rx == 0 || ry == 0) continue;
        west  = (c == CORNER_UL || c == CORNER_LL);
        north = (c == CORNER_UL || c == CORNER_UR);
        cx = west ? l + rx : r - rx;
        cy = north ? t + ry : b - ry;
        if (west ? !(x < cx) : !(x > cx)) continue;
        if (north ? !(y < cy) : !(y > cy)) continue;
        adx = west ? cx - x : x - cx;
        ady = north ? cy - y : y - cy;
        dx2 = adx * adx;
        dy2 = ady * ady;
        rx2 = rx * rx;
        ry2 = ry * ry;
        return (dx2 * ry2 + dy2 * rx2 <= rx2 * ry2);
      end
      return 1'b1;
    endfunction

    function void note_point(logic signed [BOX_W-1:0] x, logic signed [BOX_W-1:0] y);
      hit_expect_t e;
      e.x = x;
      e.y = y;
      e.hit = point_hits(x, y);
      hit_q.push_back(e);
    endfunction

    function void check_result(logic got);
      hit_expect_t e;
      if (hit_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result %b with no point pending", got);
        return;
      end
      e = hit_q.pop_front();
      checked++;
      if (e.hit) hits++;
      else misses++;
      if (got !== e.hit) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: point (%0d,%0d) expected %b got %b", e.x, e.y, e.hit, got);
      end
    endfunction

    function int pending();
      return hit_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [BOX_W-1:0] point_x_i;
  logic signed [BOX_W-1:0] point_y_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  inside_res_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  hit_scoreboard sb = new();
  bit hold_req = 1'b0;
  int settings_cnt = 0;
  int cycle_cnt = 0;

  rounded_rect_point_hit_test_top #(
    .COORD_WIDTH(BOX_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .inside_res_o (inside_res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int clamp16(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int near_coord(int lo, int hi);
    int m;
    m = (hi - lo) / 4 + 8;
    return clamp16(lo - m + $urandom_range(0, hi - lo + 2 * m));
  endfunction

  function automatic logic [15:0] pick_radius(int s);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 10) v = 0;
    else if (r < 60) v = $urandom_range(1, (s < 1) ? 1 : s);
    else if (r < 85) v = $urandom_range(1, 2 * s + 16);
    else v = $urandom_range(0, 65535);
    return v[15:0];
  endfunction

  function automatic logic [31:0] rand_radii(int w, int h);
    return {pick_radius(h / 2), pick_radius(w / 2)};
  endfunction

  task automatic program_shape(input int l, input int t, input int r, input int b,
                               input logic [31:0] ul, input logic [31:0] ur,
                               input logic [31:0] lr, input logic [31:0] ll);
    logic [CFG_DATA_W-1:0] vals [8];
    cfg_reg_e idx;
    vals[REG_BOX_LEFT]          = $urandom();
    vals[REG_BOX_TOP]           = $urandom();
    vals[REG_BOX_RIGHT]         = $urandom();
    vals[REG_BOX_BOTTOM]        = $urandom();
    vals[REG_BOX_LEFT][15:0]    = l[15:0];
    vals[REG_BOX_TOP][15:0]     = t[15:0];
    vals[REG_BOX_RIGHT][15:0]   = r[15:0];
    vals[REG_BOX_BOTTOM][15:0]  = b[15:0];
    vals[REG_UPPER_LEFT_RADII]  = ul;
    vals[REG_UPPER_RIGHT_RADII] = ur;
    vals[REG_LOWER_RIGHT_RADII] = lr;
    vals[REG_LOWER_LEFT_RADII]  = ll;
    idx = idx.first();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= vals[idx];
      @(posedge clk_i);
      sb.write_reg(idx, vals[idx]);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  task automatic send_point(input logic signed [BOX_W-1:0] x,
                            input logic signed [BOX_W-1:0] y, input bit busy);
    int gap;
    gap = busy ? 0 : (($urandom_range(0, 99) < 55) ? 0 : idle_len());
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_point(x, y);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n_pts, input bit with_hold);
    int kind, w, h, cx, cy, l, t, r, b, tmp, x, y;
    bit busy;
    kind = $urandom_range(0, 9);
    w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12000) : $urandom_range(1, 400);
    h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12000) : $urandom_range(1, 400);
    cx = $urandom_range(0, 40000) - 20000;
    cy = $urandom_range(0, 40000) - 20000;
    l = cx - w / 2;
    r = l + w;
    t = cy - h / 2;
    b = t + h;
    case (kind)
      0: begin
        if ($urandom_range(0, 1)) begin
          tmp = l; l = r; r = tmp;
        end else begin
          tmp = t; t = b; b = tmp;
        end
      end
      1: begin
        if ($urandom_range(0, 1)) r = l;
        else b = t;
      end
      2: begin
        l = $urandom_range(0, 65535) - 32768;
        r = $urandom_range(0, 65535) - 32768;
        t = $urandom_range(0, 65535) - 32768;
        b = $urandom_range(0, 65535) - 32768;
        w = 40000;
        h = 40000;
      end
      default: ;
    endcase
    program_shape(l, t, r, b, rand_radii(w, h), rand_radii(w, h),
                  rand_radii(w, h), rand_radii(w, h));
    if (l > r) begin
      tmp = l; l = r; r = tmp;
    end
    if (t > b) begin
      tmp = t; t = b; b = tmp;
    end
    busy = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_pts; i++) begin
      if (with_hold && i == n_pts / 4) hold_req = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        x = $urandom_range(0, 65535) - 32768;
        y = $urandom_range(0, 65535) - 32768;
      end else begin
        x = near_coord(l, r);
        y = near_coord(t, b);
      end
      send_point(x[15:0], y[15:0], busy);
    end
    settle();
  endtask

  initial begin : result_side
    int run_left, hold_left;
    bit run_stall;
    run_left = 0;
    hold_left = 0;
    run_stall = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(inside_res_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 99) < 30);
          run_left = run_stall ? idle_len() : $urandom_range(1, 40);
        end
        run_left--;
        out_stall_i <= run_stall;
      end
    end
  end

  initial begin : watchdog
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt >= LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : point_side
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    point_x_i   = '0;
    point_y_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset shape: degenerate box at the origin
    send_point(0, 0, 1'b0);
    send_point(0, 1, 1'b0);
    send_point(-32768, -32768, 1'b0);
    send_point(32767, 32767, 1'b0);
    settle();

    // square corner, oversized corner and plain elliptical corners
    program_shape(-1600, -800, 1600, 800, 32'h00A0_0140, 32'h0000_0140,
                  32'h0FA0_0FA0, 32'h00C8_0064);
    send_point(-1600, -800, 1'b0);
    send_point(-1280, -640, 1'b0);
    send_point(-1500, -750, 1'b0);
    send_point(1600, -800, 1'b0);
    send_point(1600, 800, 1'b0);
    send_point(-1600, 800, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(1601, 0, 1'b0);
    send_point(0, -801, 1'b0);
    send_point(-1600, 0, 1'b0);
    settle();

    // inverted box
    program_shape(100, 0, -100, 0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_point(0, 0, 1'b0);
    send_point(100, 0, 1'b0);
    settle();

    // zero width box with rounded corners
    program_shape(80, -160, 80, 160, 32'h0010_0010, 32'h0010_0010,
                  32'h0010_0010, 32'h0010_0010);
    send_point(80, 0, 1'b0);
    send_point(80, 160, 1'b0);
    send_point(81, 0, 1'b0);
    settle();

    // full range box, largest radii
    program_shape(-32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(-32768, -32768, 1'b0);
    send_point(32767, 32767, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(-32768, 32767, 1'b0);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) random_phase(PHASE_PTS, p == 2);

    $display("Covered %0d points over %0d box settings: %0d inside, %0d outside.",
             sb.checked, settings_cnt, sb.hits, sb.misses);
    $display("Mismatches %0d, one output hold-off of %0d cycles, %0d cycles run.",
             sb.errors, HOLD_CYCLES, cycle_cnt);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/rrht_pkg.sv
hdl/rrht_sqr.sv
hdl/rounded_rect_point_hit_test_top.sv
hdl/rrht_checker.sv
dv/rounded_rect_point_hit_test_top_tb.sv
